// File: hdl/pgalloc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pgalloc_pkg
// Shared types, constants and helpers for the page allocator.
// ============================================================================
package pgalloc_pkg;

    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;
    localparam int REF_BITS   = 8;

    localparam int ADDR_W     = 40;
    localparam int PCOUNT_W   = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    // page number of an address, plus one bit for the round-up carry
    localparam int PN_W       = ADDR_W - PAGE_SHIFT + 1;

    localparam logic [ADDR_W-1:0]   FIRST_PAGE_ADDR_RST = 40'h00_8000_0000;
    localparam logic [PCOUNT_W-1:0] PAGE_COUNT_RST      = 16'd32768;
    localparam logic [REF_BITS-1:0] REF_MAX             = {REF_BITS{1'b1}};
    localparam logic [IDX_W-1:0]    LAST_IDX            = IDX_W'(MAX_PAGES - 1);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_ADDREF = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ADDR  = 3'd1,
        ST_NO_MEM    = 3'd2,
        ST_UNREF     = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE_ADDR = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT      = 4'd1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    // page_count clipped to MAX_PAGES
    function automatic logic [CNT_W-1:0] eff_pages(input logic [PCOUNT_W-1:0] pc);
        logic [31:0] wide;
        wide = 32'(pc);
        if (wide > 32'(MAX_PAGES))
            wide = 32'(MAX_PAGES);
        return CNT_W'(wide);
    endfunction

    // page number of the first page, rounded up
    function automatic logic [PN_W-1:0] base_pn(input logic [ADDR_W-1:0] a);
        return PN_W'(a[ADDR_W-1:PAGE_SHIFT]) + PN_W'(|a[PAGE_SHIFT-1:0]);
    endfunction

endpackage

// File: hdl/pgalloc_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// pgalloc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module pgalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/page_allocator_with_refcounts.sv
`timescale 1ns / 1ps
// ============================================================================
// page_allocator_with_refcounts
// Physical page allocator with per-page reference counts and a LIFO free list.
// ============================================================================
// Each command passes from S_IDLE to S_EXEC: the transfer edge reads the count
// and link memories, S_EXEC writes them back and puts the result on the output
// ports for one cycle with done high; busy is low again in that cycle, so a new
// command may be taken then but not earlier. The result cannot be held off.
// After reset and after a write to either configuration register, a clearing
// pass zeroes all MAX_PAGES count entries, one entry a cycle, with busy high.
module page_allocator_with_refcounts (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pgalloc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pgalloc_pkg::ADDR_W-1:0]        cfg_wdata,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            op,
    input  logic [pgalloc_pkg::ADDR_W-1:0]        page_addr,
    output logic                                  done,
    output logic [2:0]                            status,
    output logic [pgalloc_pkg::ADDR_W-1:0]        result_addr,
    output logic [pgalloc_pkg::REF_BITS-1:0]      ref_count,
    output logic [pgalloc_pkg::CNT_W-1:0]         free_pages,
    output logic                                  released
);

    import pgalloc_pkg::*;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [PN_W-1:0]      base_pn_reg, base_pn_next;
    logic [CNT_W-1:0]     eff_reg, eff_next;
    logic [IDX_W-1:0]     stack_head_reg, stack_head_next;
    logic                 stack_empty_reg, stack_empty_next;
    logic [CNT_W-1:0]     untouched_reg, untouched_next;
    logic [CNT_W-1:0]     free_cnt_reg, free_cnt_next;
    logic                 done_reg, done_next;

    // command captured at the transfer
    op_t                  op_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 hit_reg;

    logic [2:0]           status_reg, status_next;
    logic [ADDR_W-1:0]    raddr_reg, raddr_next;
    logic [REF_BITS-1:0]  rc_reg, rc_next;
    logic [CNT_W-1:0]     free_out_reg, free_out_next;
    logic                 rel_reg, rel_next;

    // address decode
    logic [PN_W-1:0]      addr_pn;
    logic [PN_W-1:0]      diff_pn;
    logic                 hit;
    logic                 accept;

    // memory ports
    logic                 rc_we;
    logic [IDX_W-1:0]     rc_waddr;
    logic [REF_BITS-1:0]  rc_wdata;
    logic [REF_BITS-1:0]  rc_rdata;
    logic                 nf_we;
    logic [IDX_W-1:0]     nf_rdata;

    logic [CNT_W-1:0]     stacked;
    logic [IDX_W-1:0]     alloc_idx;
    logic [PN_W-1:0]      alloc_pn;
    logic [PCOUNT_W-1:0]  pc_new;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign addr_pn = PN_W'(page_addr[ADDR_W-1:PAGE_SHIFT]);
    assign diff_pn = addr_pn - base_pn_reg;
    assign hit     = (page_addr[PAGE_SHIFT-1:0] == '0) && (addr_pn >= base_pn_reg)
                     && (diff_pn < PN_W'(eff_reg));

    assign stacked  = free_cnt_reg - untouched_reg;
    assign alloc_pn = base_pn_reg + PN_W'(alloc_idx);
    assign pc_new   = cfg_wdata[PCOUNT_W-1:0];

    pgalloc_ram #(
        .WIDTH (REF_BITS),
        .DEPTH (MAX_PAGES)
    ) u_ref_ram (
        .clk   (clk),
        .we    (rc_we),
        .waddr (rc_waddr),
        .wdata (rc_wdata),
        .raddr (diff_pn[IDX_W-1:0]),
        .rdata (rc_rdata)
    );

    pgalloc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (nf_we),
        .waddr (idx_reg),
        .wdata (stack_head_reg),
        .raddr (stack_head_reg),
        .rdata (nf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            base_pn_reg     <= base_pn(FIRST_PAGE_ADDR_RST);
            eff_reg         <= eff_pages(PAGE_COUNT_RST);
            stack_head_reg  <= '0;
            stack_empty_reg <= 1'b1;
            untouched_reg   <= eff_pages(PAGE_COUNT_RST);
            free_cnt_reg    <= eff_pages(PAGE_COUNT_RST);
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            base_pn_reg     <= base_pn_next;
            eff_reg         <= eff_next;
            stack_head_reg  <= stack_head_next;
            stack_empty_reg <= stack_empty_next;
            untouched_reg   <= untouched_next;
            free_cnt_reg    <= free_cnt_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(op);
            addr_reg <= page_addr;
            idx_reg  <= diff_pn[IDX_W-1:0];
            hit_reg  <= hit;
        end
        status_reg   <= status_next;
        raddr_reg    <= raddr_next;
        rc_reg       <= rc_next;
        free_out_reg <= free_out_next;
        rel_reg      <= rel_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        base_pn_next     = base_pn_reg;
        eff_next         = eff_reg;
        stack_head_next  = stack_head_reg;
        stack_empty_next = stack_empty_reg;
        untouched_next   = untouched_reg;
        free_cnt_next    = free_cnt_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        raddr_next       = raddr_reg;
        rc_next          = rc_reg;
        free_out_next    = free_out_reg;
        rel_next         = rel_reg;
        rc_we            = 1'b0;
        rc_waddr         = idx_reg;
        rc_wdata         = '0;
        nf_we            = 1'b0;
        alloc_idx        = stack_head_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                rc_we    = 1'b1;
                rc_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next    = S_IDLE;
                done_next     = 1'b1;
                status_next   = ST_OK;
                raddr_next    = addr_reg;
                rc_next       = '0;
                rel_next      = 1'b0;
                if (op_reg == OP_ALLOC)
                begin
                    if (!stack_empty_reg)
                    begin
                        alloc_idx = stack_head_reg;
                        if (stacked <= CNT_W'(1))
                            stack_empty_next = 1'b1;
                        else
                            stack_head_next = nf_rdata;
                    end
                    else if (untouched_reg != '0)
                    begin
                        alloc_idx      = IDX_W'(untouched_reg - 1'b1);
                        untouched_next = untouched_reg - 1'b1;
                    end
                    if (!stack_empty_reg || (untouched_reg != '0))
                    begin
                        rc_we         = 1'b1;
                        rc_waddr      = alloc_idx;
                        rc_wdata      = REF_BITS'(1);
                        rc_next       = REF_BITS'(1);
                        free_cnt_next = free_cnt_reg - 1'b1;
                        raddr_next    = {alloc_pn[PN_W-2:0], {PAGE_SHIFT{1'b0}}};
                    end
                    else
                    begin
                        status_next = ST_NO_MEM;
                        raddr_next  = '0;
                    end
                end
                else if (!hit_reg)
                begin
                    status_next = ST_BAD_ADDR;
                end
                else
                begin
                    rc_next = rc_rdata;
                    unique case (op_reg)
                        OP_FREE:
                        begin
                            if (rc_rdata == '0)
                            begin
                                status_next = ST_UNREF;
                            end
                            else
                            begin
                                rc_we    = 1'b1;
                                rc_wdata = rc_rdata - 1'b1;
                                rc_next  = rc_rdata - 1'b1;
                                if (rc_rdata == REF_BITS'(1))
                                begin
                                    // last reference gone: push onto the free list
                                    nf_we            = 1'b1;
                                    stack_head_next  = idx_reg;
                                    stack_empty_next = 1'b0;
                                    free_cnt_next    = free_cnt_reg + 1'b1;
                                    rel_next         = 1'b1;
                                end
                            end
                        end
                        OP_ADDREF:
                        begin
                            if (rc_rdata == '0)
                                status_next = ST_UNREF;
                            else if (rc_rdata == REF_MAX)
                                status_next = ST_SATURATED;
                            else
                            begin
                                rc_we    = 1'b1;
                                rc_wdata = rc_rdata + 1'b1;
                                rc_next  = rc_rdata + 1'b1;
                            end
                        end
                        default:
                        begin
                            // query, and allocate which is handled above
                        end
                    endcase
                end
                free_out_next = free_cnt_next;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // a write to either configuration register restarts the allocator
        if (cfg_we && ((cfg_index == REG_FIRST_PAGE_ADDR) || (cfg_index == REG_PAGE_COUNT)))
        begin
            if (cfg_index == REG_FIRST_PAGE_ADDR)
            begin
                base_pn_next   = base_pn(cfg_wdata);
                untouched_next = eff_reg;
                free_cnt_next  = eff_reg;
            end
            else
            begin
                eff_next       = eff_pages(pc_new);
                untouched_next = eff_pages(pc_new);
                free_cnt_next  = eff_pages(pc_new);
            end
            state_next       = S_CLEAR;
            clr_cnt_next     = '0;
            stack_head_next  = '0;
            stack_empty_next = 1'b1;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign result_addr = raddr_reg;
    assign ref_count   = rc_reg;
    assign free_pages  = free_out_reg;
    assign released    = rel_reg;

endmodule
